@@ sv/ivs_pkg.sv @@
// ----------------------------------------------------------------------------
// ivs_pkg
// Shared widths, reset values, register indexes and types of the irrigation
// valve sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ivs_pkg;

	// Field widths
	localparam int MOIST_W = 12;
	localparam int MS_W    = 10;
	localparam int SEC_W   = 6;
	localparam int ACC_W   = 11;  // below one second plus one item's milliseconds
	localparam int RUNS_W  = 8;
	localparam int PUMP_W  = 16;
	localparam int SERVO_W = 13;

	localparam int SENSOR_COUNT    = 3;
	localparam int VALVE_COUNT_DEF = 3;
	localparam int MS_PER_SECOND   = 1000;

	// Stream packing
	localparam int IN_FIELDS_W  = SENSOR_COUNT * MOIST_W + MS_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = SENSOR_COUNT + PUMP_W + SERVO_W + 1 + (SENSOR_COUNT + 1) * SEC_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] CFG_DRY_THRESHOLD      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WATERING_SECONDS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAINTENANCE_LENGTH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_LIMIT        = 2'd3;

	// Reset values
	localparam logic [MOIST_W-1:0] RST_DRY_THRESHOLD = 12'd1500;
	localparam logic [SEC_W-1:0]   RST_SECONDS       = 6'd30;
	localparam logic [RUNS_W-1:0]  RST_CYCLE_LIMIT   = 8'd2;

	// Output levels
	localparam logic [PUMP_W-1:0]  PUMP_OFF_LEVEL = 16'd0;
	localparam logic [PUMP_W-1:0]  PUMP_ON_LEVEL  = 16'd39062;
	localparam logic [SERVO_W-1:0] SERVO_IDLE     = 13'd976;
	localparam logic [SERVO_W-1:0] SERVO_ONE      = 13'd1953;
	localparam logic [SERVO_W-1:0] SERVO_TWO      = 13'd3515;
	localparam logic [SERVO_W-1:0] SERVO_MORE     = 13'd4687;

	typedef struct packed {
		logic [MOIST_W-1:0] dry_threshold;
		logic [SEC_W-1:0]   watering_seconds;
		logic [SEC_W-1:0]   maintenance_length;
		logic [RUNS_W-1:0]  cycle_limit;
	} cfg_t;

	typedef struct packed {
		logic               maint_active;
		logic [SEC_W-1:0]   maint_seconds;
		logic [ACC_W-1:0]   maint_ms_accum;
		logic [RUNS_W-1:0]  finished_runs;
	} ctrl_t;

	typedef struct packed {
		logic [SEC_W-1:0]                   maint_left;
		logic [SENSOR_COUNT-1:0][SEC_W-1:0] left;
		logic                               in_maintenance;
		logic [SERVO_W-1:0]                 servo_level;
		logic [PUMP_W-1:0]                  pump_level;
		logic [SENSOR_COUNT-1:0]            valve_mask;
	} result_t;

endpackage

`default_nettype wire

@@ sv/ivs_update.sv @@
// ----------------------------------------------------------------------------
// ivs_update
// Next-state and result logic for one item: valve opening, per-valve second
// ticks, run counting, maintenance entry and exit, pump and servo levels.
// ----------------------------------------------------------------------------
`default_nettype none

module ivs_update #(
	parameter int VALVE_COUNT = ivs_pkg::VALVE_COUNT_DEF
) (
	input  ivs_pkg::cfg_t                                            cfg,
	input  logic [ivs_pkg::SENSOR_COUNT-1:0][ivs_pkg::MOIST_W-1:0] moisture,
	input  logic [ivs_pkg::MS_W-1:0]                                elapsed_ms,
	input  logic [VALVE_COUNT-1:0]                                  running,
	input  logic [VALVE_COUNT-1:0][ivs_pkg::SEC_W-1:0]              seconds,
	input  logic [VALVE_COUNT-1:0][ivs_pkg::ACC_W-1:0]              ms_accum,
	input  ivs_pkg::ctrl_t                                           ctrl,
	output logic [VALVE_COUNT-1:0]                                  next_running,
	output logic [VALVE_COUNT-1:0][ivs_pkg::SEC_W-1:0]              next_seconds,
	output logic [VALVE_COUNT-1:0][ivs_pkg::ACC_W-1:0]              next_ms_accum,
	output ivs_pkg::ctrl_t                                           next_ctrl,
	output ivs_pkg::result_t                                         result
);

	localparam int CNT_W = (VALVE_COUNT >= 3) ? $clog2(VALVE_COUNT + 1) : 2;
	localparam logic [ivs_pkg::ACC_W-1:0] ONE_SECOND = ivs_pkg::ACC_W'(ivs_pkg::MS_PER_SECOND);

	logic [VALVE_COUNT-1:0][ivs_pkg::MOIST_W-1:0] sample;
	logic [ivs_pkg::ACC_W-1:0]                    ms_ext;
	logic [ivs_pkg::ACC_W-1:0]                    acc;
	logic [ivs_pkg::ACC_W-1:0]                    macc;
	logic [ivs_pkg::SEC_W-1:0]                    sec;
	logic                                         stop;
	logic [CNT_W-1:0]                             active;
	logic [ivs_pkg::SERVO_W-1:0]                  servo;

	assign ms_ext = ivs_pkg::ACC_W'(elapsed_ms);

	// valves without a sensor see a dry-proof sample of zero
	for (genvar g = 0; g < VALVE_COUNT; g++) begin : g_sample
		if (g < ivs_pkg::SENSOR_COUNT) begin : g_real
			assign sample[g] = moisture[g];
		end else begin : g_none
			assign sample[g] = '0;
		end
	end

	always_comb begin
		next_running  = running;
		next_seconds  = seconds;
		next_ms_accum = ms_accum;
		next_ctrl     = ctrl;
		stop          = 1'b0;
		acc           = '0;
		sec           = '0;
		macc          = ctrl.maint_ms_accum + ms_ext;

		if (ctrl.maint_active) begin
			// sensors ignored for the whole item
			if (macc >= ONE_SECOND) begin
				next_ctrl.maint_ms_accum = '0;
				if (ctrl.maint_seconds != '0) begin
					next_ctrl.maint_seconds = ctrl.maint_seconds - 1'b1;
				end else begin
					next_ctrl.maint_active  = 1'b0;
					next_ctrl.finished_runs = '0;
				end
			end else begin
				next_ctrl.maint_ms_accum = macc;
			end
		end else begin
			// valve order matters: a maintenance entry skips the rest
			for (int v = 0; v < VALVE_COUNT; v++) begin
				acc = ms_accum[v] + ms_ext;
				sec = seconds[v];
				if (!stop) begin
					if (!running[v]) begin
						if (sample[v] > cfg.dry_threshold) begin
							next_running[v]  = 1'b1;
							next_seconds[v]  = cfg.watering_seconds;
							next_ms_accum[v] = '0;
						end
					end else if (acc >= ONE_SECOND) begin
						next_ms_accum[v] = '0;
						if (sec != '0) begin
							sec = sec - 1'b1;
						end
						next_seconds[v] = sec;
						if (sec == '0) begin
							next_running[v] = 1'b0;
							if (next_ctrl.finished_runs != '1) begin
								next_ctrl.finished_runs = next_ctrl.finished_runs + 1'b1;
							end
							if (next_ctrl.finished_runs >= cfg.cycle_limit) begin
								next_running             = '0;
								next_ctrl.maint_active   = 1'b1;
								next_ctrl.maint_seconds  = cfg.maintenance_length;
								next_ctrl.maint_ms_accum = '0;
								stop                     = 1'b1;
							end
						end
					end else begin
						next_ms_accum[v] = acc;
					end
				end
			end
		end
	end

	always_comb begin
		active = '0;
		for (int v = 0; v < VALVE_COUNT; v++) begin
			active = active + CNT_W'(next_running[v]);
		end
	end

	for (genvar g = 0; g < ivs_pkg::SENSOR_COUNT; g++) begin : g_out
		if (g < VALVE_COUNT) begin : g_real
			assign result.valve_mask[g] = next_running[g];
			assign result.left[g]       = next_seconds[g];
		end else begin : g_none
			assign result.valve_mask[g] = 1'b0;
			assign result.left[g]       = '0;
		end
	end

	assign result.pump_level     = (active != '0) ? ivs_pkg::PUMP_ON_LEVEL
	                                              : ivs_pkg::PUMP_OFF_LEVEL;
	assign result.in_maintenance = next_ctrl.maint_active;
	assign result.maint_left     = next_ctrl.maint_seconds;
	assign result.servo_level    = servo;

	always_comb begin
		priority if (active == CNT_W'(0)) begin
			servo = ivs_pkg::SERVO_IDLE;
		end else if (active == CNT_W'(1)) begin
			servo = ivs_pkg::SERVO_ONE;
		end else if (active == CNT_W'(2)) begin
			servo = ivs_pkg::SERVO_TWO;
		end else begin
			servo = ivs_pkg::SERVO_MORE;
		end
	end

endmodule

`default_nettype wire

@@ sv/irrigation_valve_sequencer.sv @@
// ----------------------------------------------------------------------------
// irrigation_valve_sequencer
// Opens valves on dry soil samples, times each watering run in seconds from
// per-item millisecond deltas, and enters a timed maintenance hold after a
// set number of finished runs.
// ----------------------------------------------------------------------------
// Throughput: one request per clock while the output side is not stalled; the
//   update is a single pass of logic. Path: an accepted request is held in the
//   input register, and its result is loaded into the output register when
//   the output side can take it.
// Reset: arst_n clears all valves, run count, accumulators and the stream
//   valids; countdowns reload 30, registers take their default values.
// ----------------------------------------------------------------------------
`default_nettype none

module irrigation_valve_sequencer #(
	parameter int VALVE_COUNT = ivs_pkg::VALVE_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_wen,
	input  logic [ivs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ivs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	// input stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// soil_0, soil_1, soil_2, elapsed_ms, zero pad
	input  logic [ivs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// result stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// valve_mask, pump_level, servo_level, in_maintenance,
	// left_0, left_1, left_2, maint_left, zero pad
	output logic [ivs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int MOIST_BITS       = ivs_pkg::SENSOR_COUNT * ivs_pkg::MOIST_W;
	localparam int MOISTURE_BITS_HI = MOIST_BITS - 1;

	// configuration registers
	ivs_pkg::cfg_t cfg_q;

	// input register
	logic                                                            valid_s1;
	logic [ivs_pkg::SENSOR_COUNT-1:0][ivs_pkg::MOIST_W-1:0]          moisture_s1;
	logic [ivs_pkg::MS_W-1:0]                                        elapsed_s1;

	// sequencer state
	logic [VALVE_COUNT-1:0]                        running_q;
	logic [VALVE_COUNT-1:0][ivs_pkg::SEC_W-1:0]    seconds_q;
	logic [VALVE_COUNT-1:0][ivs_pkg::ACC_W-1:0]    accum_q;
	ivs_pkg::ctrl_t                                ctrl_q;

	// next state from the update logic
	logic [VALVE_COUNT-1:0]                        running_d;
	logic [VALVE_COUNT-1:0][ivs_pkg::SEC_W-1:0]    seconds_d;
	logic [VALVE_COUNT-1:0][ivs_pkg::ACC_W-1:0]    accum_d;
	ivs_pkg::ctrl_t                                ctrl_d;
	ivs_pkg::result_t                              result_d;

	// output register
	logic             m_valid_q;
	ivs_pkg::result_t result_q;

	logic s_accept;
	logic advance;

	// The state commits when the held request moves into the output register,
	// so a stalled output never lets the state run ahead of delivered results.
	assign advance       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dry_threshold      <= ivs_pkg::RST_DRY_THRESHOLD;
			cfg_q.watering_seconds   <= ivs_pkg::RST_SECONDS;
			cfg_q.maintenance_length <= ivs_pkg::RST_SECONDS;
			cfg_q.cycle_limit        <= ivs_pkg::RST_CYCLE_LIMIT;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				ivs_pkg::CFG_DRY_THRESHOLD: begin
					cfg_q.dry_threshold <= cfg_wdata[ivs_pkg::MOIST_W-1:0];
				end
				ivs_pkg::CFG_WATERING_SECONDS: begin
					cfg_q.watering_seconds <= cfg_wdata[ivs_pkg::SEC_W-1:0];
				end
				ivs_pkg::CFG_MAINTENANCE_LENGTH: begin
					cfg_q.maintenance_length <= cfg_wdata[ivs_pkg::SEC_W-1:0];
				end
				ivs_pkg::CFG_CYCLE_LIMIT: begin
					cfg_q.cycle_limit <= cfg_wdata[ivs_pkg::RUNS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// input register: valid under reset, payload loads on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			moisture_s1 <= s_axis_tdata[MOISTURE_BITS_HI:0];
			elapsed_s1  <= s_axis_tdata[MOIST_BITS +: ivs_pkg::MS_W];
		end
	end

	ivs_update #(
		.VALVE_COUNT (VALVE_COUNT)
	) u_update (
		.cfg           (cfg_q),
		.moisture      (moisture_s1),
		.elapsed_ms    (elapsed_s1),
		.running       (running_q),
		.seconds       (seconds_q),
		.ms_accum      (accum_q),
		.ctrl          (ctrl_q),
		.next_running  (running_d),
		.next_seconds  (seconds_d),
		.next_ms_accum (accum_d),
		.next_ctrl     (ctrl_d),
		.result        (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			accum_q   <= '0;
			for (int v = 0; v < VALVE_COUNT; v++) begin
				seconds_q[v] <= ivs_pkg::RST_SECONDS;
			end
			ctrl_q.maint_active   <= 1'b0;
			ctrl_q.maint_seconds  <= ivs_pkg::RST_SECONDS;
			ctrl_q.maint_ms_accum <= '0;
			ctrl_q.finished_runs  <= '0;
		end else if (advance) begin
			running_q <= running_d;
			seconds_q <= seconds_d;
			accum_q   <= accum_d;
			ctrl_q    <= ctrl_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {
		{(ivs_pkg::OUT_TDATA_W - ivs_pkg::OUT_FIELDS_W){1'b0}},
		result_q.maint_left,
		result_q.left,
		result_q.in_maintenance,
		result_q.servo_level,
		result_q.pump_level,
		result_q.valve_mask
	};

endmodule

`default_nettype wire

@@ dv/irrigation_result_checker.sv @@
// ----------------------------------------------------------------------------
// irrigation_result_checker
// Watches the configuration port and both streams of the valve sequencer,
// predicts the result of every accepted request and compares it field by
// field with what the block returns, oldest first.
// ----------------------------------------------------------------------------

module irrigation_result_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [ivs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ivs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [ivs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [ivs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output int                              fail_count,
	output int                              pending,
	output int                              results_seen,
	output int                              maint_entries,
	output int                              maint_exits,
	output int                              runs_done
);
	timeunit 1ns;
	timeprecision 1ps;
	import ivs_pkg::*;

	// register copy
	logic [MOIST_W-1:0]      thr;
	logic [SEC_W-1:0]        water_secs;
	logic [SEC_W-1:0]        maint_len;
	logic [RUNS_W-1:0]       run_limit;
	// sequencer state
	logic [SENSOR_COUNT-1:0] running;
	logic [SEC_W-1:0]        secs [SENSOR_COUNT];
	int                      accum [SENSOR_COUNT];
	logic [RUNS_W-1:0]       runs;
	logic                    maint_on;
	logic [SEC_W-1:0]        maint_secs;
	int                      maint_acc;

	result_t                 expected_q [$];
	int                      reported;

	task automatic clear_model();
		int v;
		thr        = RST_DRY_THRESHOLD;
		water_secs = RST_SECONDS;
		maint_len  = RST_SECONDS;
		run_limit  = RST_CYCLE_LIMIT;
		running    = '0;
		for (v = 0; v < SENSOR_COUNT; v++) begin
			secs[v]  = RST_SECONDS;
			accum[v] = 0;
		end
		runs       = '0;
		maint_on   = 1'b0;
		maint_secs = RST_SECONDS;
		maint_acc  = 0;
	endtask

	task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_DRY_THRESHOLD:      thr        = data[MOIST_W-1:0];
			CFG_WATERING_SECONDS:   water_secs = data[SEC_W-1:0];
			CFG_MAINTENANCE_LENGTH: maint_len  = data[SEC_W-1:0];
			CFG_CYCLE_LIMIT:        run_limit  = data[RUNS_W-1:0];
			default: ;
		endcase
	endtask

	// One request: maintenance ticking, or a pass over the valves that stops
	// as soon as a finished run starts maintenance.
	task automatic predict_valves(input logic [IN_TDATA_W-1:0] req, output result_t res);
		logic [MS_W-1:0]    ms;
		logic [MOIST_W-1:0] sample;
		int                 v;
		int                 open_cnt;
		bit                 stop;
		ms       = req[SENSOR_COUNT*MOIST_W +: MS_W];
		stop     = 1'b0;
		open_cnt = 0;
		if (maint_on) begin
			maint_acc += ms;
			if (maint_acc >= MS_PER_SECOND) begin
				maint_acc = 0;
				if (maint_secs != 0) begin
					maint_secs--;
				end else begin
					maint_on = 1'b0;
					runs     = '0;
					maint_exits++;
				end
			end
		end else begin
			for (v = 0; v < SENSOR_COUNT; v++) begin
				if (!stop) begin
					sample = req[v*MOIST_W +: MOIST_W];
					if (!running[v]) begin
						// fresh valve: no tick in the request that opens it
						if (sample > thr) begin
							running[v] = 1'b1;
							secs[v]    = water_secs;
							accum[v]   = 0;
						end
					end else begin
						accum[v] += ms;
						if (accum[v] >= MS_PER_SECOND) begin
							accum[v] = 0;  // leftover ms are dropped
							if (secs[v] != 0)
								secs[v]--;
							if (secs[v] == 0) begin
								running[v] = 1'b0;
								runs_done++;
								if (runs != 8'd255)
									runs++;
								if (runs >= run_limit) begin
									running    = '0;
									maint_on   = 1'b1;
									maint_secs = maint_len;
									maint_acc  = 0;
									stop       = 1'b1;
									maint_entries++;
								end
							end
						end
					end
				end
			end
		end
		res = '0;
		for (v = 0; v < SENSOR_COUNT; v++) begin
			if (running[v])
				open_cnt++;
			res.left[v] = secs[v];
		end
		res.valve_mask     = running;
		res.pump_level     = (open_cnt > 0) ? PUMP_ON_LEVEL : PUMP_OFF_LEVEL;
		case (open_cnt)
			0:       res.servo_level = SERVO_IDLE;
			1:       res.servo_level = SERVO_ONE;
			2:       res.servo_level = SERVO_TWO;
			default: res.servo_level = SERVO_MORE;
		endcase
		res.in_maintenance = maint_on;
		res.maint_left     = maint_secs;
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		bit      bad;
		results_seen++;
		if (expected_q.size() == 0) begin
			fail_count++;
			if (reported < 10)
				$display("%0t: result with no request outstanding: %h", $realtime, got);
			reported++;
		end else begin
			want = expected_q.pop_front();
			bad  = (got.valve_mask !== want.valve_mask)
				|| (got.pump_level !== want.pump_level)
				|| (got.servo_level !== want.servo_level)
				|| (got.in_maintenance !== want.in_maintenance)
				|| (got.left[0] !== want.left[0])
				|| (got.left[1] !== want.left[1])
				|| (got.left[2] !== want.left[2])
				|| (got.maint_left !== want.maint_left);
			if (bad) begin
				fail_count++;
				if (reported < 10) begin
					$display("%0t: result %0d mismatch", $realtime, results_seen);
					$display("  exp mask=%b pump=%0d servo=%0d maint=%b left=%0d/%0d/%0d mleft=%0d",
						want.valve_mask, want.pump_level, want.servo_level,
						want.in_maintenance, want.left[0], want.left[1], want.left[2],
						want.maint_left);
					$display("  got mask=%b pump=%0d servo=%0d maint=%b left=%0d/%0d/%0d mleft=%0d",
						got.valve_mask, got.pump_level, got.servo_level,
						got.in_maintenance, got.left[0], got.left[1], got.left[2],
						got.maint_left);
				end
				reported++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t res;
		if (!arst_n) begin
			clear_model();
			expected_q.delete();
			fail_count    = 0;
			pending       = 0;
			results_seen  = 0;
			maint_entries = 0;
			maint_exits   = 0;
			runs_done     = 0;
			reported      = 0;
		end else begin
			if (cfg_wen)
				apply_register(cfg_index, cfg_wdata);
			if (m_axis_tvalid && m_axis_tready)
				check_result(m_axis_tdata[OUT_FIELDS_W-1:0]);
			if (s_axis_tvalid && s_axis_tready) begin
				predict_valves(s_axis_tdata, res);
				expected_q.push_back(res);
			end
			pending = expected_q.size();
		end
	end

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench top for the irrigation valve sequencer: drives directed and random
// moisture requests under several register settings and stall patterns, and
// reports the verdict from the result checker.
// ----------------------------------------------------------------------------

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ivs_pkg::*;

	localparam int REQS_PER_PHASE = 240;
	localparam int RANDOM_PHASES  = 6;
	localparam int STALL_LIMIT    = 3000;  // cycles without any handshake
	localparam int HOLD_CYCLES    = 300;   // long output back-pressure stretch

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_wen;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	// soil_0, soil_1, soil_2, elapsed_ms, zero pad
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	// valve_mask, pump_level, servo_level, in_maintenance,
	// left_0, left_1, left_2, maint_left, zero pad
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	int fail_count;
	int pending;
	int results_seen;
	int maint_entries;
	int maint_exits;
	int runs_done;

	// stall knobs for the sender and the receiver process
	int send_idle_pct;
	int recv_idle_pct;
	int hold_cycles;

	int requests_sent;
	int settings_used;
	logic [MOIST_W-1:0] cur_thr;  // threshold last written, steers samples
	int stall_cnt;

	always #5 clk = ~clk;

	irrigation_valve_sequencer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	irrigation_result_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending       (pending),
		.results_seen  (results_seen),
		.maint_entries (maint_entries),
		.maint_exits   (maint_exits),
		.runs_done     (runs_done)
	);

	function automatic bit draw_idle(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic logic [IN_TDATA_W-1:0] pack_request(input logic [MOIST_W-1:0] m0,
			input logic [MOIST_W-1:0] m1, input logic [MOIST_W-1:0] m2,
			input logic [MS_W-1:0] ms);
		logic [IN_TDATA_W-1:0] data;
		data = '0;
		data[0*MOIST_W +: MOIST_W]            = m0;
		data[1*MOIST_W +: MOIST_W]            = m1;
		data[2*MOIST_W +: MOIST_W]            = m2;
		data[SENSOR_COUNT*MOIST_W +: MS_W]    = ms;
		return data;
	endfunction

	// Samples cluster on the threshold and the rails, the rest spread out.
	function automatic logic [MOIST_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return cur_thr;
			3:       return (cur_thr == '1) ? cur_thr : cur_thr + 1'b1;
			default: return MOIST_W'($urandom_range(0, 4095));
		endcase
	endfunction

	// Mostly large steps so countdowns actually move.
	function automatic logic [MS_W-1:0] pick_elapsed();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3:    return MS_W'($urandom_range(0, 1023));
			default: return MS_W'($urandom_range(500, 1023));
		endcase
	endfunction

	// Offer one request; returns just after the edge that took it.
	// tvalid stays high so back-to-back requests need no extra edge.
	task automatic send_request(input logic [IN_TDATA_W-1:0] data);
		@(negedge clk);
		while (draw_idle(send_idle_pct)) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		do @(posedge clk); while (!s_axis_tready);
		requests_sent++;
	endtask

	// Stop offering and let every outstanding result come back.
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Raw 12-bit values; the block keeps only each register's width.
	task automatic write_settings(input logic [CFG_DATA_W-1:0] thr,
			input logic [CFG_DATA_W-1:0] water, input logic [CFG_DATA_W-1:0] mlen,
			input logic [CFG_DATA_W-1:0] limit);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= CFG_DRY_THRESHOLD;
		cfg_wdata <= thr;
		@(negedge clk);
		cfg_index <= CFG_WATERING_SECONDS;
		cfg_wdata <= water;
		@(negedge clk);
		cfg_index <= CFG_MAINTENANCE_LENGTH;
		cfg_wdata <= mlen;
		@(negedge clk);
		cfg_index <= CFG_CYCLE_LIMIT;
		cfg_wdata <= limit;
		@(negedge clk);
		cfg_wen   <= 1'b0;
		cur_thr = thr[MOIST_W-1:0];
		settings_used++;
	endtask

	// Receiver: random back-pressure, or a counted hold when one is armed.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				hold_cycles--;
			end else begin
				m_axis_tready <= !draw_idle(recv_idle_pct);
			end
		end
	end

	// Watchdog: any handshake on either side resets the count.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cnt = 0;
		else
			stall_cnt++;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("watchdog: %0d cycles without a handshake", STALL_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int p;
		int n;
		arst_n        = 1'b0;
		cfg_wen       = 1'b0;
		cfg_index     = CFG_DRY_THRESHOLD;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		send_idle_pct = 37;
		recv_idle_pct = 63;
		hold_cycles   = 0;
		requests_sent = 0;
		settings_used = 1;  // reset values count as the first setting
		cur_thr       = RST_DRY_THRESHOLD;
		stall_cnt     = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Reset values: threshold boundary, valve opening with the default
		// countdown, and a fresh valve that does not tick on its first request.
		send_request(pack_request(12'd0, 12'd0, 12'd0, 10'd0));
		send_request(pack_request(12'd1500, 12'd1500, 12'd1500, 10'd1023));
		send_request(pack_request(12'd0, 12'd0, 12'd1501, 10'd0));
		send_request(pack_request(12'd0, 12'd4095, 12'd0, 10'd1023));
		wait_drained();

		// Upper bits written are dropped: watering 1, maintenance 0, limit 1.
		write_settings(12'd2000, 12'hFC1, 12'hFC0, 12'hF01);
		// valve 0 opens short while 1 and 2 run long
		send_request(pack_request(12'd4095, 12'd0, 12'd0, 10'd1023));
		// valve 0 finishes and starts maintenance; 1 and 2 must not tick
		send_request(pack_request(12'd0, 12'd0, 12'd0, 10'd1000));
		// maintenance ignores dry sensors, also on the request that ends it
		send_request(pack_request(12'd4095, 12'd4095, 12'd4095, 10'd999));
		send_request(pack_request(12'd4095, 12'd4095, 12'd4095, 10'd1));
		send_request(pack_request(12'd4095, 12'd4095, 12'd4095, 10'd0));
		send_request(pack_request(12'd0, 12'd0, 12'd0, 10'd1023));
		send_request(pack_request(12'd0, 12'd0, 12'd0, 10'd1023));
		wait_drained();

		// Threshold at full scale: nothing can be dry.
		write_settings(12'd4095, 12'd0, 12'd2, 12'd0);
		send_request(pack_request(12'd4095, 12'd4095, 12'd4095, 10'd1023));
		wait_drained();

		// Zero threshold, zero watering time, zero cycle limit.
		write_settings(12'd0, 12'd0, 12'd2, 12'd0);
		send_request(pack_request(12'd1, 12'd0, 12'd0, 10'd500));
		send_request(pack_request(12'd0, 12'd0, 12'd0, 10'd500));
		send_request(pack_request(12'd0, 12'd0, 12'd0, 10'd500));
		wait_drained();

		for (p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0, 1: begin
					send_idle_pct = 37;
					recv_idle_pct = 63;
				end
				2, 3: begin
					send_idle_pct = 63;
					recv_idle_pct = 37;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (p)
				// short runs and low limits so maintenance comes often
				0: write_settings(12'($urandom_range(1000, 3000)), 12'($urandom_range(1, 3)),
						12'($urandom_range(0, 4)), 12'($urandom_range(1, 4)));
				// every time and limit at its top value, threshold at zero
				1: write_settings(12'd0, 12'd63, 12'd63, 12'd255);
				// only full-scale samples are dry, every run starts maintenance
				2: write_settings(12'd4094, 12'd1, 12'd0, 12'd1);
				3: write_settings(12'($urandom_range(0, 4095)), 12'($urandom_range(1, 8)),
						12'($urandom_range(0, 8)), 12'($urandom_range(1, 6)));
				4: write_settings(12'($urandom_range(500, 3500)), 12'($urandom_range(1, 4)),
						12'($urandom_range(0, 3)), 12'($urandom_range(1, 5)));
				default: write_settings(12'($urandom_range(0, 4095)),
						12'($urandom_range(1, 10)), 12'($urandom_range(0, 10)),
						12'($urandom_range(1, 10)));
			endcase
			for (n = 0; n < REQS_PER_PHASE; n++) begin
				// long output hold while requests keep coming: fills the
				// pipeline until the input side stalls
				if (p == 4 && n == 60)
					hold_cycles = HOLD_CYCLES;
				send_request(pack_request(pick_sample(), pick_sample(), pick_sample(),
					pick_elapsed()));
			end
			wait_drained();
		end

		repeat (10) @(negedge clk);
		$display("Sent %0d moisture requests under %0d register settings, %0d results checked.",
			requests_sent, settings_used, results_seen);
		$display("Predicted %0d finished runs, %0d maintenance entries, %0d exits.",
			runs_done, maint_entries, maint_exits);
		if (fail_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d failures, %0d results outstanding", fail_count, pending);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
sv/ivs_pkg.sv
sv/ivs_update.sv
sv/irrigation_valve_sequencer.sv
dv/irrigation_result_checker.sv
dv/tb.sv
